@@ hdl/spq_pkg.sv @@
// Package: shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int PRIO_W = 8;
  localparam int OUT_PRIO_W = PRIO_W + 1;
  localparam int OCC_W = 5;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // one stored entry as it moves between neighboring cells
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
  } entry_t;

  // command broadcast to every cell in the row
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
  } cmd_t;

endpackage

@@ hdl/spq_if.sv @@
// Interfaces: request and result channels with valid/ready handshake
interface spq_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic signed [31:0] data;
  logic [7:0]        priority_req;

  modport source (output valid, output kind, output data, output priority_req, input ready);
  modport sink   (input valid, input kind, input data, input priority_req, output ready);
endinterface

interface spq_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] out_data;
  logic signed [8:0] out_priority;
  logic [1:0]        status;
  logic [4:0]        occupancy;

  modport source (output valid, output out_data, output out_priority, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input out_data, input out_priority, input status,
                  input occupancy, output ready);
endinterface

@@ hdl/spq_cell.sv @@
// Cell: one slot of the sorted row, holds, loads new, or shifts from a neighbor
module spq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::entry_t left_ent,
  input  logic           left_ge,
  input  spq_pkg::entry_t right_ent,
  output spq_pkg::entry_t ent,
  output logic           ge
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  assign ge  = ent_r.valid && (ent_r.prio >= cmd.prio);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.enq) begin
      if (!ge) begin
        if (left_ge) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.data  = cmd.data;
          ent_nxt.prio  = cmd.prio;
        end else begin
          ent_nxt = left_ent;
        end
      end
    end else if (cmd.deq) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

@@ hdl/sorted_priority_queue_core.sv @@
// Top level: sorted priority queue built from a row of shifting compare cells
//
//   channel | dir | handshake   | payload
//   in_ch   | in  | valid/ready | kind, data, priority_req
//   out_ch  | out | valid/ready | out_data, out_priority, status, occupancy
//
// One beat per cycle unless stalled: every cell compares its priority against
// the broadcast request and holds or shifts one step toward or away from the
// front. The result is registered; in_ch.ready is low only while a result is
// held and out_ch.ready is low. Reset clears the valid bits and count.
module sorted_priority_queue_core #(
  parameter int CAPACITY = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  entry_t ents [CAPACITY];
  logic   ges  [CAPACITY];
  cmd_t   cmd;

  logic fire;
  logic full;
  logic empty;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic                         out_valid_r;
  logic signed [DATA_W-1:0]     out_data_r;
  logic signed [OUT_PRIO_W-1:0] out_prio_r;
  status_t                      status_r;
  logic [OCC_W-1:0]             occ_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire  = in_ch.valid && in_ch.ready;
  assign full  = ents[CAPACITY-1].valid;
  assign empty = !ents[0].valid;

  assign cmd.enq  = fire && (in_ch.kind == KIND_ENQ) && !full;
  assign cmd.deq  = fire && (in_ch.kind == KIND_DEQ) && !empty;
  assign cmd.data = in_ch.data;
  assign cmd.prio = in_ch.priority_req;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t l_ent;
    entry_t r_ent;
    logic   l_ge;

    if (i == 0) begin : g_first
      assign l_ent = '0;
      assign l_ge  = 1'b1;
    end else begin : g_mid
      assign l_ent = ents[i-1];
      assign l_ge  = ges[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_ent = '0;
    end else begin : g_inner
      assign r_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (l_ent),
      .left_ge   (l_ge),
      .right_ent (r_ent),
      .ent       (ents[i]),
      .ge        (ges[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      occ_r <= OCC_W'(count_nxt);
      if (in_ch.kind == KIND_DEQ) begin
        if (empty) begin
          out_data_r <= '1;
          out_prio_r <= '1;
          status_r   <= STATUS_EMPTY;
        end else begin
          out_data_r <= ents[0].data;
          out_prio_r <= {1'b0, ents[0].prio};
          status_r   <= STATUS_DONE;
        end
      end else begin
        out_data_r <= '0;
        out_prio_r <= '0;
        status_r   <= full ? STATUS_FULL : STATUS_DONE;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_data     = out_data_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.status       = status_r;
  assign out_ch.occupancy    = occ_r;

endmodule
